@@ rtl/core/bed_pkg.sv @@
// Package for the bounded entry deque: entry and result types, command and
// status codes, default capacity. No dependencies.
package bed_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int COUNT_W      = 5;

    typedef enum logic [1:0] {
        CMD_POP_FRONT  = 2'd0,
        CMD_PUSH_FRONT = 2'd1,
        CMD_PUSH_BACK  = 2'd2,
        CMD_SET_TIME   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_EVICTED = 2'd3
    } t_status;

    typedef struct packed {
        logic [15:0]        kind;
        logic signed [31:0] etime;
        logic [31:0]        param_first;
        logic [31:0]        param_second;
        logic [31:0]        param_third;
    } t_entry;

    typedef struct packed {
        t_status              status;
        logic                 front_valid;
        t_entry               front;
        logic [COUNT_W-1:0]   entry_count;
    } t_result;

endpackage

@@ rtl/core/bed_if.sv @@
// Valid/ready channel interfaces for the deque command and response
// transactions. Depends on nothing.
interface bed_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [15:0]        entry_kind;
    logic signed [31:0] entry_time;
    logic [31:0]        param_first;
    logic [31:0]        param_second;
    logic [31:0]        param_third;

    modport source (output valid, command, entry_kind, entry_time, param_first,
                    param_second, param_third, input ready);
    modport sink   (input valid, command, entry_kind, entry_time, param_first,
                    param_second, param_third, output ready);
endinterface

interface bed_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic               front_valid;
    logic [15:0]        front_kind;
    logic signed [31:0] front_time;
    logic [31:0]        front_param_first;
    logic [31:0]        front_param_second;
    logic [31:0]        front_param_third;
    logic [4:0]         entry_count;

    modport source (output valid, status, front_valid, front_kind, front_time,
                    front_param_first, front_param_second, front_param_third,
                    entry_count, input ready);
    modport sink   (input valid, status, front_valid, front_kind, front_time,
                    front_param_first, front_param_second, front_param_third,
                    entry_count, output ready);
endinterface

@@ rtl/core/bounded_entry_deque_top.sv @@
// Bounded entry deque top level: ring buffer with head pointer and count.
// Throughput: one command per cycle unless a held response stalls it; front
// and next-entry registers plus one registered memory read per cycle keep
// every operation single-pass. The result is registered on command accept.
// Reset: synchronous active-low, clears head, count and response valid.
// Depends on bed_pkg and bed_if.
module bounded_entry_deque_top
    import bed_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bed_cmd_if.sink   i_cmd_ch,
    bed_rsp_if.source o_rsp_ch
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = IW + 1;

    t_entry          r_mem [CAPACITY];
    logic [IW-1:0]   r_head;
    logic [CW-1:0]   r_count;
    logic            r_out_valid;
    t_entry          r_front;
    t_entry          r_next;
    t_result         r_out;

    logic [IW-1:0]   n_head;
    logic [CW-1:0]   n_count;
    t_entry          n_front;
    t_status         status;
    t_cmd            cmd;
    t_entry          in_entry;
    logic            accept;
    logic            full;
    logic            empty;
    logic [IW-1:0]   head_inc;
    logic [IW-1:0]   head_inc2;
    logic [IW-1:0]   head_dec;
    logic [SW-1:0]   tail_sum;
    logic [IW-1:0]   tail;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    t_entry          wr_data;
    logic [IW-1:0]   rd_addr;
    logic            next_from_mem;
    t_entry          next_hold;

    assign accept = i_cmd_ch.valid && i_cmd_ch.ready;
    assign i_cmd_ch.ready = !r_out_valid || o_rsp_ch.ready;
    assign cmd = t_cmd'(i_cmd_ch.command);

    assign in_entry.kind         = i_cmd_ch.entry_kind;
    assign in_entry.etime        = i_cmd_ch.entry_time;
    assign in_entry.param_first  = i_cmd_ch.param_first;
    assign in_entry.param_second = i_cmd_ch.param_second;
    assign in_entry.param_third  = i_cmd_ch.param_third;

    assign full  = (r_count == CW'(CAPACITY));
    assign empty = (r_count == '0);

    assign head_inc  = (r_head == IW'(CAPACITY - 1)) ? '0 : r_head + 1'b1;
    assign head_inc2 = (head_inc == IW'(CAPACITY - 1)) ? '0 : head_inc + 1'b1;
    assign head_dec  = (r_head == '0) ? IW'(CAPACITY - 1) : r_head - 1'b1;
    assign tail_sum  = SW'(r_head) + SW'(r_count);
    assign tail      = (tail_sum >= SW'(CAPACITY)) ? IW'(tail_sum - SW'(CAPACITY))
                                                   : IW'(tail_sum);

    always_comb begin
        n_head        = r_head;
        n_count       = r_count;
        n_front       = r_front;
        status        = ST_DONE;
        wr_en         = 1'b0;
        wr_addr       = r_head;
        wr_data       = in_entry;
        rd_addr       = head_inc;
        next_from_mem = 1'b1;
        next_hold     = r_next;
        case (cmd)
            CMD_POP_FRONT: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    n_head  = head_inc;
                    n_count = r_count - 1'b1;
                    n_front = r_next;
                    rd_addr = head_inc2;
                end
            end
            CMD_PUSH_FRONT: begin
                n_head        = head_dec;
                wr_en         = 1'b1;
                wr_addr       = head_dec;
                n_front       = in_entry;
                next_from_mem = 1'b0;
                next_hold     = r_front;
                if (full) begin
                    status = ST_EVICTED;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            CMD_PUSH_BACK: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = tail;
                    n_count = r_count + 1'b1;
                    if (empty) begin
                        n_front = in_entry;
                    end
                end
            end
            CMD_SET_TIME: begin
                next_from_mem = 1'b0;
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    wr_en         = 1'b1;
                    wr_data       = r_front;
                    wr_data.etime = in_entry.etime;
                    n_front.etime = in_entry.etime;
                end
            end
            default: begin
                status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
                r_head      <= n_head;
                r_count     <= n_count;
            end else if (o_rsp_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // next register tracks the slot after the head, bypassing same-cycle writes
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (wr_en) begin
                r_mem[wr_addr] <= wr_data;
            end
            r_front <= n_front;
            if (next_from_mem) begin
                r_next <= (wr_en && wr_addr == rd_addr) ? wr_data : r_mem[rd_addr];
            end else begin
                r_next <= next_hold;
            end
            r_out.status      <= status;
            r_out.front_valid <= (n_count != '0);
            r_out.front       <= (n_count != '0) ? n_front : '0;
            r_out.entry_count <= COUNT_W'(n_count);
        end
    end

    assign o_rsp_ch.valid              = r_out_valid;
    assign o_rsp_ch.status             = r_out.status;
    assign o_rsp_ch.front_valid        = r_out.front_valid;
    assign o_rsp_ch.front_kind         = r_out.front.kind;
    assign o_rsp_ch.front_time         = r_out.front.etime;
    assign o_rsp_ch.front_param_first  = r_out.front.param_first;
    assign o_rsp_ch.front_param_second = r_out.front.param_second;
    assign o_rsp_ch.front_param_third  = r_out.front.param_third;
    assign o_rsp_ch.entry_count        = r_out.entry_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= IW'(CAPACITY - 1))
        else $error("head index out of ring");

    a_front_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.front_valid == (r_count != '0)))
        else $error("front_valid disagrees with count");

    a_push_back_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && cmd == CMD_PUSH_BACK && full)
        |=> (r_out.status == ST_FULL && $stable(r_count) && $stable(r_head)))
        else $error("push back on full queue changed state");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && cmd == CMD_POP_FRONT && empty)
        |=> (r_out.status == ST_EMPTY && r_count == '0))
        else $error("pop on empty queue misreported");

endmodule

@@ tb/bounded_entry_deque_checker.sv @@
`timescale 1ns / 100ps
// Checker for the bounded entry deque: watches the command and response channels,
// keeps its own ring model of the deque and compares every response in order.
// Depends on bed_pkg and the channel interfaces in bed_if.
module bounded_entry_deque_checker
    import bed_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    bed_cmd_if   i_cmd_mon,
    bed_rsp_if   i_rsp_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    localparam int DEPTH      = DEF_CAPACITY;
    localparam int REPORT_MAX = 10;

    t_entry  ring_mem [DEPTH];
    int      head_slot;
    int      held;
    t_result front_expect [$];
    int      fail_count;
    int      checked;

    // Applies one command to the ring model and queues the response it gives.
    task automatic predict_front(input t_cmd cmd, input t_entry item);
        t_result r;
        r = '0;
        r.status = ST_DONE;
        case (cmd)
            CMD_POP_FRONT: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    head_slot = (head_slot + 1) % DEPTH;
                    held--;
                end
            end
            CMD_PUSH_FRONT: begin
                head_slot = (head_slot + DEPTH - 1) % DEPTH;
                ring_mem[head_slot] = item;
                if (held >= DEPTH) begin
                    r.status = ST_EVICTED;
                end else begin
                    held++;
                end
            end
            CMD_PUSH_BACK: begin
                if (held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    ring_mem[(head_slot + held) % DEPTH] = item;
                    held++;
                end
            end
            default: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    ring_mem[head_slot].etime = item.etime;
                end
            end
        endcase
        r.front_valid = (held != 0);
        if (held != 0) begin
            r.front = ring_mem[head_slot];
        end
        r.entry_count = held[COUNT_W-1:0];
        front_expect.push_back(r);
    endtask

    always @(posedge i_clk) begin : monitor
        t_entry  item;
        t_result seen;
        t_result want;
        bit      bad;
        if (!i_rst_n) begin
            front_expect.delete();
            head_slot = 0;
            held = 0;
            fail_count = 0;
            checked = 0;
        end else begin
            if (i_cmd_mon.valid && i_cmd_mon.ready) begin
                item.kind         = i_cmd_mon.entry_kind;
                item.etime        = i_cmd_mon.entry_time;
                item.param_first  = i_cmd_mon.param_first;
                item.param_second = i_cmd_mon.param_second;
                item.param_third  = i_cmd_mon.param_third;
                predict_front(t_cmd'(i_cmd_mon.command), item);
            end
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                seen.status             = t_status'(i_rsp_mon.status);
                seen.front_valid        = i_rsp_mon.front_valid;
                seen.front.kind         = i_rsp_mon.front_kind;
                seen.front.etime        = i_rsp_mon.front_time;
                seen.front.param_first  = i_rsp_mon.front_param_first;
                seen.front.param_second = i_rsp_mon.front_param_second;
                seen.front.param_third  = i_rsp_mon.front_param_third;
                seen.entry_count        = i_rsp_mon.entry_count;
                if (front_expect.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $display("%0t: unexpected response transaction status=%0d count=%0d",
                                 $realtime, seen.status, seen.entry_count);
                    end
                end else begin
                    want = front_expect.pop_front();
                    checked++;
                    bad = (seen.status !== want.status)
                       || (seen.front_valid !== want.front_valid)
                       || (seen.front.kind !== want.front.kind)
                       || (seen.front.etime !== want.front.etime)
                       || (seen.front.param_first !== want.front.param_first)
                       || (seen.front.param_second !== want.front.param_second)
                       || (seen.front.param_third !== want.front.param_third)
                       || (seen.entry_count !== want.entry_count);
                    if (bad) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX) begin
                            $display("%0t: response %0d mismatch", $realtime, checked);
                            $display("  exp: st=%0d fv=%0d kind=%h time=%h p=%h %h %h cnt=%0d",
                                     want.status, want.front_valid, want.front.kind,
                                     want.front.etime, want.front.param_first,
                                     want.front.param_second, want.front.param_third,
                                     want.entry_count);
                            $display("  got: st=%0d fv=%0d kind=%h time=%h p=%h %h %h cnt=%0d",
                                     seen.status, seen.front_valid, seen.front.kind,
                                     seen.front.etime, seen.front.param_first,
                                     seen.front.param_second, seen.front.param_third,
                                     seen.entry_count);
                        end
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= front_expect.size();
        o_checked    <= checked;
    end

endmodule

@@ tb/bounded_entry_deque_top_test.sv @@
`timescale 1ns / 100ps
// Testbench top for the bounded entry deque: clock, reset, command stimulus with
// idle profiles and a long response stall, watchdog and verdict.
// Depends on bed_pkg, bed_if, bounded_entry_deque_top and the deque checker.
module bounded_entry_deque_top_test;
    import bed_pkg::*;

    localparam int DEPTH        = DEF_CAPACITY;
    localparam int STALL_CYCLES = 80;
    localparam int WATCHDOG_MAX = 3000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 350;

    logic clk = 1'b0;
    logic rst_n;

    bed_cmd_if cmd_ch ();
    bed_rsp_if rsp_ch ();

    int fail_count;
    int pending;
    int checked;
    int tx_idle_pct;
    int rx_idle_pct;
    int stall_req;
    int stall_seen;
    int stall_left;
    int idle_cycles;
    int items_sent;

    bounded_entry_deque_top u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_cmd_ch (cmd_ch),
        .o_rsp_ch (rsp_ch)
    );

    bounded_entry_deque_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd_mon    (cmd_ch),
        .i_rsp_mon    (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #6 clk = ~clk;

    // Response side: random back-pressure, plus a counted hold-off on request.
    always @(posedge clk) begin
        if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (stall_req != stall_seen) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= STALL_CYCLES - 1;
            stall_seen   <= stall_req;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_MAX) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_MAX);
            $display("[bounded_entry_deque_top] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(11))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_command(input t_cmd cmd, input logic [15:0] kind,
                                input logic [31:0] etime, input logic [31:0] p1,
                                input logic [31:0] p2, input logic [31:0] p3);
        while ($urandom_range(99) < tx_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.command      <= cmd;
        cmd_ch.entry_kind   <= kind;
        cmd_ch.entry_time   <= etime;
        cmd_ch.param_first  <= p1;
        cmd_ch.param_second <= p2;
        cmd_ch.param_third  <= p3;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_random(input t_cmd cmd);
        send_command(cmd, 16'($urandom), pick_word(), pick_word(), pick_word(), pick_word());
    endtask

    // Biased mix: push_pct sets how often a push is picked, to sweep fill level.
    task automatic send_mixed(input int push_pct);
        if ($urandom_range(99) < push_pct) begin
            send_random($urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK);
        end else begin
            send_random($urandom_range(3) == 0 ? CMD_SET_TIME : CMD_POP_FRONT);
        end
    endtask

    initial begin
        int bias;
        cmd_ch.valid        = 1'b0;
        cmd_ch.command      = CMD_POP_FRONT;
        cmd_ch.entry_kind   = '0;
        cmd_ch.entry_time   = '0;
        cmd_ch.param_first  = '0;
        cmd_ch.param_second = '0;
        cmd_ch.param_third  = '0;
        rsp_ch.ready        = 1'b0;
        rst_n               = 1'b0;
        tx_idle_pct         = 17;
        rx_idle_pct         = 88;
        stall_req           = 0;
        stall_seen          = 0;
        stall_left          = 0;
        idle_cycles         = 0;
        items_sent          = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty cases, fill with extremes, full cases
        send_random(CMD_POP_FRONT);
        send_random(CMD_SET_TIME);
        for (int i = 0; i < DEPTH; i++) begin
            if (i % 4 == 0) begin
                send_command(CMD_PUSH_FRONT, 16'hFFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF);
            end else if (i % 4 == 1) begin
                send_command(CMD_PUSH_BACK, 16'h0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
            end else begin
                send_random(i % 2 ? CMD_PUSH_BACK : CMD_PUSH_FRONT);
            end
        end
        send_random(CMD_PUSH_BACK);
        send_random(CMD_PUSH_FRONT);
        send_command(CMD_SET_TIME, 16'h1234, 32'h8000_0000, 32'h5, 32'h6, 32'h7);
        send_command(CMD_SET_TIME, 16'h4321, 32'h7FFF_FFFF, 32'h8, 32'h9, 32'hA);
        send_random(CMD_POP_FRONT);

        // random: three idle profiles, push bias swept to reach full and empty
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                tx_idle_pct = 88;
                rx_idle_pct = 17;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (n % 25 == 0) begin
                case ($urandom_range(2))
                    0: bias = 85;
                    1: bias = 15;
                    default: bias = 50;
                endcase
            end
            send_mixed(bias);
        end

        // long response hold-off while commands keep coming
        stall_req <= stall_req + 1;
        for (int n = 0; n < 30; n++) begin
            send_mixed(70);
        end
        cmd_ch.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d commands: empty and full edge cases, biased random fill/drain,",
                 items_sent);
        $display("three idle profiles and an %0d-cycle response stall; %0d responses checked",
                 STALL_CYCLES, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("[bounded_entry_deque_top] OK");
        end else begin
            $display("%0d failures, %0d responses missing", fail_count, pending);
            $display("[bounded_entry_deque_top] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/bed_pkg.sv
rtl/core/bed_if.sv
rtl/core/bounded_entry_deque_top.sv
tb/bounded_entry_deque_checker.sv
tb/bounded_entry_deque_top_test.sv
